// ----- design/hmap_pkg.sv -----
// ----------------------------------------------------------------------------
// hmap_pkg: shared definitions of the hex mesh index mapper
// Field widths, register indexes, face codes and the pipeline stage record.
// ----------------------------------------------------------------------------
package hmap_pkg;

  // Largest cell count per axis; the field widths below are sized for it.
  localparam int MAX_CELLS_PER_AXIS = 64;

  localparam int CNT_W  = 7;
  localparam int NUM_W  = 20;
  localparam int VOL_W  = 18;
  localparam int FACE_W = 3;
  localparam int CODE_W = 5;
  localparam int NODE_W = 19;
  localparam int BC_W   = 24;
  localparam int XY_W   = 14;
  localparam int PXY_W  = 15;
  localparam int TOT_W  = 21;
  localparam int THR_W  = 17;
  localparam int Q_W    = 7;
  localparam int REM_W  = 21;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  localparam logic [CNT_W-1:0]  CNT_RESET      = 7'd30;
  localparam logic [CODE_W-1:0] DIRICHLET_BUMP = 5'd10;

  typedef enum logic [1:0] {
    REG_ELEMS_X = 2'd0,
    REG_ELEMS_Y = 2'd1,
    REG_ELEMS_Z = 2'd2,
    REG_FACE_BC = 2'd3
  } reg_idx_t;

  typedef enum logic [FACE_W-1:0] {
    FACE_ZMIN = 3'd0,
    FACE_ZMAX = 3'd1,
    FACE_YMIN = 3'd2,
    FACE_YMAX = 3'd3,
    FACE_XMIN = 3'd4,
    FACE_XMAX = 3'd5
  } face_t;

  typedef struct packed {
    logic              v;
    logic              bnd;
    logic              err;
    logic [NUM_W-1:0]  n;
    logic [CNT_W-1:0]  nx;
    logic [CNT_W-1:0]  ny;
    logic [CNT_W-1:0]  nz;
    logic [XY_W-1:0]   xy;
    logic [XY_W-1:0]   xz;
    logic [XY_W-1:0]   yz;
    logic [PXY_W-1:0]  pxy;
    logic [TOT_W-1:0]  tot;
    logic [THR_W-1:0]  thr1;
    logic [THR_W-1:0]  thr2;
    logic [THR_W-1:0]  thr3;
    logic [THR_W-1:0]  thr4;
    logic [THR_W-1:0]  thr5;
    logic [FACE_W-1:0] face;
    logic [CODE_W-1:0] code;
    logic [REM_W-1:0]  rem;
    logic [XY_W-1:0]   dvs;
    logic [Q_W-1:0]    q;
    logic [CNT_W-1:0]  bmul;
    logic [REM_W-1:0]  base;
    logic [REM_W-1:0]  pa;
    logic [XY_W-1:0]   pb;
    logic [REM_W-1:0]  cell_num;
    logic [Q_W-1:0]    k;
    logic [NODE_W-1:0] node;
  } stage_t;

endpackage

// ----- design/hmap_if.sv -----
// ----------------------------------------------------------------------------
// hmap_if: request and result channels of the hex mesh index mapper
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hmap_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [hmap_pkg::NUM_W-1:0] elem_number;

  modport source(output valid, req_type, elem_number, input ready);
  modport sink(input valid, req_type, elem_number, output ready);
endinterface

interface hmap_res_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [hmap_pkg::VOL_W-1:0]  volume_index;
  logic [hmap_pkg::FACE_W-1:0] face_id;
  logic [hmap_pkg::CODE_W-1:0] bc_code;
  logic [hmap_pkg::NODE_W-1:0] corner0;
  logic [hmap_pkg::NODE_W-1:0] corner1;
  logic [hmap_pkg::NODE_W-1:0] corner2;
  logic [hmap_pkg::NODE_W-1:0] corner3;
  logic [hmap_pkg::NODE_W-1:0] corner4;
  logic [hmap_pkg::NODE_W-1:0] corner5;
  logic [hmap_pkg::NODE_W-1:0] corner6;
  logic [hmap_pkg::NODE_W-1:0] corner7;

  modport source(output valid, status, volume_index, face_id, bc_code, corner0, corner1,
                 corner2, corner3, corner4, corner5, corner6, corner7, input ready);
  modport sink(input valid, status, volume_index, face_id, bc_code, corner0, corner1,
               corner2, corner3, corner4, corner5, corner6, corner7, output ready);
endinterface

// ----- design/hex_mesh_element_index_mapper_core.sv -----
// ----------------------------------------------------------------------------
// hex_mesh_element_index_mapper_core: structured hex grid index mapper
// Maps volume and boundary element numbers to cell number, face, boundary
// code and the eight corner node numbers, in a 30-stage pipeline followed by
// an output register.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | contents
//   --------+-----------+------------------------+------------------------------
//   req     | in        | valid / ready          | req_type, elem_number
//   res     | out       | valid / ready          | status, cell, face, code, corners
//   apb     | in        | psel, penable, pready  | elems_x/y/z, face_bc_codes
//
// One request can enter per cycle unless a stall on res reaches the first stage.
// The pipeline holds three restoring dividers (face row, z layer, y row), each
// resolving one quotient bit per stage, plus the multiply stages around them.
// Reset is synchronous: valid bits and face_bc_codes clear, elems_x/y/z load 30.
// A stall on res holds each full stage whose successor cannot take data, so
// bubbles are squeezed out and a request is never dropped or duplicated.
//
module hex_mesh_element_index_mapper_core (
  input  logic                        clk,
  input  logic                        rst,
  hmap_req_if.sink                    req,
  hmap_res_if.source                  res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hmap_pkg::ADDR_W-1:0] paddr,
  input  logic [hmap_pkg::DATA_W-1:0] pwdata,
  output logic [hmap_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import hmap_pkg::*;

  // p[0] captures the request; p[NP-1] feeds the output register.
  localparam int NP = 30;

  logic [CNT_W-1:0] elems_x;
  logic [CNT_W-1:0] elems_y;
  logic [CNT_W-1:0] elems_z;
  logic [BC_W-1:0]  face_bc_codes;

  stage_t p [NP];
  stage_t s0;
  logic [NP:0] ld;

  logic              res_v;
  logic              res_status;
  logic [VOL_W-1:0]  res_vol;
  logic [FACE_W-1:0] res_face;
  logic [CODE_W-1:0] res_code;
  logic [NODE_W-1:0] res_c [8];
  logic [NODE_W-1:0] c_next [8];

  // ---------------------------------------------------------------- registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      elems_x       <= CNT_RESET;
      elems_y       <= CNT_RESET;
      elems_z       <= CNT_RESET;
      face_bc_codes <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_ELEMS_X: elems_x <= pwdata[CNT_W-1:0];
        REG_ELEMS_Y: elems_y <= pwdata[CNT_W-1:0];
        REG_ELEMS_Z: elems_z <= pwdata[CNT_W-1:0];
        REG_FACE_BC: face_bc_codes <= pwdata[BC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_ELEMS_X: prdata = DATA_W'(elems_x);
      REG_ELEMS_Y: prdata = DATA_W'(elems_y);
      REG_ELEMS_Z: prdata = DATA_W'(elems_z);
      REG_FACE_BC: prdata = DATA_W'(face_bc_codes);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- functions
  // A zero count is taken as one cell, a large one is clamped to the maximum.
  function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    if (int'(v) > MAX_CELLS_PER_AXIS) return CNT_W'(MAX_CELLS_PER_AXIS);
    return v;
  endfunction

  // One step of a restoring divider: settles quotient bit b.
  function automatic stage_t div_step(stage_t x, int b);
    stage_t y;
    logic [REM_W:0] trial;
    y = x;
    trial = (REM_W+1)'(x.dvs) << b;
    if ({1'b0, x.rem} >= trial) begin
      y.rem  = x.rem - trial[REM_W-1:0];
      y.q[b] = 1'b1;
    end
    return y;
  endfunction

  function automatic stage_t stage_fn(int s, stage_t x, logic [BC_W-1:0] bc);
    stage_t y;
    logic [NUM_W-1:0] roff;
    logic [REM_W-1:0] cell_sum;
    y = x;
    roff = '0;
    cell_sum = '0;
    if (s == 1) begin
      y.xy  = XY_W'(x.nx) * XY_W'(x.ny);
      y.xz  = XY_W'(x.nx) * XY_W'(x.nz);
      y.yz  = XY_W'(x.ny) * XY_W'(x.nz);
      y.pxy = (PXY_W'(x.nx) + PXY_W'(1)) * (PXY_W'(x.ny) + PXY_W'(1));
    end else if (s == 2) begin
      y.tot  = TOT_W'(x.xy) * TOT_W'(x.nz);
      y.thr1 = THR_W'(x.xy) + THR_W'(x.xy);
      y.thr2 = y.thr1 + THR_W'(x.xz);
      y.thr3 = y.thr2 + THR_W'(x.xz);
      y.thr4 = y.thr3 + THR_W'(x.yz);
      y.thr5 = y.thr4 + THR_W'(x.yz);
    end else if (s == 3) begin
      // Face search; requests without a row split give the first divider a zero remainder.
      y.dvs  = XY_W'(x.nx);
      y.bmul = CNT_W'(1);
      y.base = '0;
      y.rem  = '0;
      y.q    = '0;
      y.face = FACE_ZMIN;
      y.err  = 1'b0;
      if (!x.bnd) begin
        y.err  = {1'b0, x.n} >= x.tot;
        y.base = REM_W'(x.n);
      end else if (x.n < NUM_W'(x.xy)) begin
        y.base = REM_W'(x.n);
      end else if (x.n < NUM_W'(x.thr1)) begin
        y.face = FACE_ZMAX;
        y.base = REM_W'(x.n) + REM_W'(x.tot) - REM_W'(x.thr1);
      end else if (x.n < NUM_W'(x.thr2)) begin
        y.face = FACE_YMIN;
        roff   = NUM_W'(x.thr1);
      end else if (x.n < NUM_W'(x.thr3)) begin
        y.face = FACE_YMAX;
        roff   = NUM_W'(x.thr2);
        y.base = REM_W'(x.xy) - REM_W'(x.nx);
      end else if (x.n < NUM_W'(x.thr4)) begin
        y.face = FACE_XMIN;
        roff   = NUM_W'(x.thr3);
        y.dvs  = XY_W'(x.ny);
        y.bmul = x.nx;
      end else if (x.n < NUM_W'(x.thr5)) begin
        y.face = FACE_XMAX;
        roff   = NUM_W'(x.thr4);
        y.dvs  = XY_W'(x.ny);
        y.bmul = x.nx;
        y.base = REM_W'(x.nx) - REM_W'(1);
      end else begin
        y.err = 1'b1;
      end
      if (x.bnd && y.face >= FACE_YMIN) y.rem = REM_W'(x.n - roff);
      y.code = '0;
      if (x.bnd) begin
        y.code = CODE_W'((bc >> {y.face, 2'b00}) & BC_W'(4'hF));
        if (bc == '0 && x.n == '0) y.code = y.code + DIRICHLET_BUMP;
      end
    end else if (s >= 4 && s <= 10) begin
      y = div_step(x, 10 - s);
    end else if (s == 11) begin
      y.pa = REM_W'(x.q) * REM_W'(x.xy);
      y.pb = XY_W'(x.rem[CNT_W-1:0]) * XY_W'(x.bmul);
    end else if (s == 12) begin
      cell_sum   = x.pa + REM_W'(x.pb) + x.base;
      y.cell_num = cell_sum;
      y.rem      = cell_sum;
      y.dvs      = x.xy;
      y.q        = '0;
    end else if (s >= 13 && s <= 19) begin
      y = div_step(x, 19 - s);
    end else if (s == 20) begin
      y.k   = x.q;
      y.dvs = XY_W'(x.nx);
      y.q   = '0;
    end else if (s >= 21 && s <= 27) begin
      y = div_step(x, 27 - s);
    end else if (s == 28) begin
      y.node = NODE_W'(x.k) * (NODE_W'(x.ny) + NODE_W'(1)) + NODE_W'(x.q);
    end else if (s == 29) begin
      y.node = x.node * (NODE_W'(x.nx) + NODE_W'(1)) + NODE_W'(x.rem[CNT_W-1:0]);
    end
    return y;
  endfunction

  // ---------------------------------------------------------------- pipeline
  // A stage loads when it is empty or its contents move on.
  always_comb begin
    ld[NP] = !res_v || res.ready;
    for (int s = NP - 1; s >= 0; s--) begin
      ld[s] = !p[s].v || ld[s+1];
    end
  end

  assign req.ready = ld[0];

  always_comb begin
    s0     = '0;
    s0.v   = req.valid;
    s0.bnd = req.req_type;
    s0.n   = req.elem_number;
    s0.nx  = eff_count(elems_x);
    s0.ny  = eff_count(elems_y);
    s0.nz  = eff_count(elems_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p[0].v <= 1'b0;
    end else if (ld[0]) begin
      p[0] <= s0;
    end
  end

  for (genvar s = 1; s < NP; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        p[s].v <= 1'b0;
      end else if (ld[s]) begin
        p[s] <= stage_fn(s, p[s-1], face_bc_codes);
      end
    end
  end

  // ---------------------------------------------------------------- output
  // Corner offsets: +1 along x, +px along y, +px*py along z.
  always_comb begin
    logic [NODE_W-1:0] px;
    logic [NODE_W-1:0] pxy;
    px  = NODE_W'(p[NP-1].nx) + NODE_W'(1);
    pxy = NODE_W'(p[NP-1].pxy);
    for (int c = 0; c < 8; c++) begin
      c_next[c] = p[NP-1].node + NODE_W'(c & 1) + (((c >> 1) & 1) != 0 ? px : '0)
                + (((c >> 2) & 1) != 0 ? pxy : '0);
      if (p[NP-1].err) c_next[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (ld[NP]) begin
      res_v      <= p[NP-1].v;
      res_status <= p[NP-1].err;
      res_vol    <= p[NP-1].err ? '0 : p[NP-1].cell_num[VOL_W-1:0];
      res_face   <= p[NP-1].err ? '0 : p[NP-1].face;
      res_code   <= p[NP-1].err ? '0 : p[NP-1].code;
      res_c      <= c_next;
    end
  end

  assign res.valid        = res_v;
  assign res.status       = res_status;
  assign res.volume_index = res_vol;
  assign res.face_id      = res_face;
  assign res.bc_code      = res_code;
  assign res.corner0      = res_c[0];
  assign res.corner1      = res_c[1];
  assign res.corner2      = res_c[2];
  assign res.corner3      = res_c[3];
  assign res.corner4      = res_c[4];
  assign res.corner5      = res_c[5];
  assign res.corner6      = res_c[6];
  assign res.corner7      = res_c[7];

`ifndef ASSERT_OFF
  a_corner_x : assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.status |-> res.corner1 == res.corner0 + NODE_W'(1))
    else $error("corner1 is not the x neighbor of corner0");

  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status |-> res.volume_index == '0 && res.face_id == '0
                                && res.bc_code == '0 && res.corner7 == '0)
    else $error("out-of-range result carries nonzero fields");

  a_face_range : assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.status |-> res.face_id <= FACE_XMAX)
    else $error("face id out of range");

  a_last_hold : assert property (@(posedge clk) disable iff (rst)
    p[NP-1].v && !ld[NP] |=> p[NP-1].v && $stable(p[NP-1].node))
    else $error("last stage changed while the output stalled");
`endif

endmodule

// ----- test/hex_mesh_element_index_mapper_core_test.sv -----
// ----------------------------------------------------------------------------
// hex_mesh_element_index_mapper_core_test: self-checking bench of the mapper
// Drives volume and boundary requests under several grid settings, predicts
// each result and compares it field by field, with random stalls on both sides.
// ----------------------------------------------------------------------------
module hex_mesh_element_index_mapper_core_test;
  import hmap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // A predicted or observed result of one request.
  typedef struct packed {
    logic              status;
    logic [VOL_W-1:0]  volume_index;
    logic [FACE_W-1:0] face_id;
    logic [CODE_W-1:0] bc_code;
    logic [7:0][NODE_W-1:0] corners;
  } mapping_t;

  localparam int LATENCY = 31;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_AXIS = MAX_CELLS_PER_AXIS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  hmap_req_if req_ch();
  hmap_res_if res_ch();

  hex_mesh_element_index_mapper_core i_dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .res(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Shadow copy of the configuration registers, as written.
  logic [CNT_W-1:0] grid_x = CNT_RESET;
  logic [CNT_W-1:0] grid_y = CNT_RESET;
  logic [CNT_W-1:0] grid_z = CNT_RESET;
  logic [BC_W-1:0]  bc_codes = '0;

  mapping_t expected_mappings[$];
  int mismatch_count = 0;
  int checked_count = 0;
  int boundary_count = 0;
  int range_error_count = 0;
  int idle_cycles = 0;
  bit stall_enable = 1'b1;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = 1'b0;
    req_ch.elem_number = '0;
    res_ch.ready = 1'b0;
  end

  // A count of zero acts as one and a count above the axis limit is clamped.
  function automatic int unsigned axis_cells(logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_AXIS) return MAX_AXIS;
    return v;
  endfunction

  function automatic int unsigned boundary_total();
    int unsigned nx, ny, nz;
    nx = axis_cells(grid_x);
    ny = axis_cells(grid_y);
    nz = axis_cells(grid_z);
    return 2 * (nx * ny + nx * nz + ny * nz);
  endfunction

  function automatic mapping_t map_element(logic is_boundary, logic [NUM_W-1:0] num);
    mapping_t m;
    int unsigned nx, ny, nz, xy, xz, yz, cell_num, r, a, b, i, j, k;
    face_t face;
    logic [3:0] code;
    nx = axis_cells(grid_x);
    ny = axis_cells(grid_y);
    nz = axis_cells(grid_z);
    xy = nx * ny;
    xz = nx * nz;
    yz = ny * nz;
    m = '0;
    face = FACE_ZMIN;
    cell_num = 0;
    if (!is_boundary) begin
      if (num >= xy * nz) begin
        m.status = 1'b1;
        return m;
      end
      cell_num = num;
    end else begin
      if (num < xy) begin
        face = FACE_ZMIN;
        cell_num = num;
      end else if (num < 2 * xy) begin
        face = FACE_ZMAX;
        cell_num = (num - xy) + xy * (nz - 1);
      end else if (num < 2 * xy + xz) begin
        face = FACE_YMIN;
        r = num - 2 * xy;
        a = r / nx;
        b = r % nx;
        cell_num = a * xy + b;
      end else if (num < 2 * (xy + xz)) begin
        face = FACE_YMAX;
        r = num - 2 * xy - xz;
        a = r / nx;
        b = r % nx;
        cell_num = a * xy + nx * (ny - 1) + b;
      end else if (num < 2 * (xy + xz) + yz) begin
        face = FACE_XMIN;
        r = num - 2 * (xy + xz);
        a = r / ny;
        b = r % ny;
        cell_num = a * xy + b * nx;
      end else if (num < 2 * (xy + xz + yz)) begin
        face = FACE_XMAX;
        r = num - 2 * (xy + xz) - yz;
        a = r / ny;
        b = r % ny;
        cell_num = a * xy + b * nx + (nx - 1);
      end else begin
        m.status = 1'b1;
        return m;
      end
      code = bc_codes[4 * face +: 4];
      m.face_id = face;
      m.bc_code = CODE_W'(code);
      // The all-zero code set marks index zero as a pure Dirichlet boundary.
      if (bc_codes == 0 && num == 0) m.bc_code = m.bc_code + DIRICHLET_BUMP;
    end
    k = cell_num / xy;
    j = (cell_num % xy) / nx;
    i = cell_num % nx;
    for (int c = 0; c < 8; c++) begin
      m.corners[c] = NODE_W'(((k + c[2]) * (ny + 1) + j + c[1]) * (nx + 1) + i + c[0]);
    end
    m.volume_index = VOL_W'(cell_num);
    return m;
  endfunction

  task automatic random_pause();
    int n;
    n = $urandom_range(1, 14);
    repeat (n) @(posedge clk);
  endtask

  // Drops the request valid while the sender waits.
  task automatic release_request();
    req_ch.valid <= 1'b0;
  endtask

  // APB write: setup cycle, then access cycle; the register takes the data
  // at the edge ending the access cycle.
  task automatic write_register(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ELEMS_X: grid_x = value[CNT_W-1:0];
      REG_ELEMS_Y: grid_y = value[CNT_W-1:0];
      REG_ELEMS_Z: grid_z = value[CNT_W-1:0];
      REG_FACE_BC: bc_codes = value[BC_W-1:0];
      default: ;
    endcase
  endtask

  // Lets the pipeline empty before the configuration changes.
  task automatic drain_results();
    release_request();
    while (expected_mappings.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_grid(int x, int y, int z, logic [BC_W-1:0] codes);
    drain_results();
    write_register(REG_ELEMS_X, DATA_W'(x));
    write_register(REG_ELEMS_Y, DATA_W'(y));
    write_register(REG_ELEMS_Z, DATA_W'(z));
    write_register(REG_FACE_BC, DATA_W'(codes));
    @(posedge clk);
  endtask

  // Sends one request; the prediction is queued when it is accepted. Valid
  // stays high afterward so requests can follow back to back.
  task automatic send_request(logic is_boundary, logic [NUM_W-1:0] num);
    if (stall_enable && $urandom_range(0, 5) == 0) begin
      release_request();
      random_pause();
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= is_boundary;
    req_ch.elem_number <= num;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_mappings.push_back(map_element(is_boundary, num));
    if (is_boundary) boundary_count++;
  endtask

  // Mostly in-range numbers, some just past the end, some anywhere.
  task automatic send_random_request();
    logic is_boundary;
    int unsigned limit, pick;
    is_boundary = $urandom_range(0, 1);
    limit = is_boundary ? boundary_total()
                        : axis_cells(grid_x) * axis_cells(grid_y) * axis_cells(grid_z);
    pick = $urandom_range(0, 9);
    if (pick < 8) send_request(is_boundary, NUM_W'($urandom_range(0, limit - 1)));
    else if (pick == 8) send_request(is_boundary, NUM_W'(limit + $urandom_range(0, 3)));
    else send_request(is_boundary, NUM_W'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_enable && res_ch.ready && $urandom_range(0, 15) == 0) begin
      res_ch.ready <= 1'b0;
    end else if (!res_ch.ready) begin
      res_ch.ready <= (!stall_enable || $urandom_range(0, 4) == 0);
    end
  end

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    mapping_t seen, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.status = res_ch.status;
      seen.volume_index = res_ch.volume_index;
      seen.face_id = res_ch.face_id;
      seen.bc_code = res_ch.bc_code;
      seen.corners = {res_ch.corner7, res_ch.corner6, res_ch.corner5, res_ch.corner4,
                      res_ch.corner3, res_ch.corner2, res_ch.corner1, res_ch.corner0};
      if (expected_mappings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("ERROR: result with no request pending");
      end else begin
        want = expected_mappings.pop_front();
        checked_count++;
        if (want.status) range_error_count++;
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: result %0d status %0d/%0d vol %0d/%0d face %0d/%0d code %0d/%0d",
                     checked_count, want.status, seen.status, want.volume_index,
                     seen.volume_index, want.face_id, seen.face_id, want.bc_code,
                     seen.bc_code);
            for (int c = 0; c < 8; c++)
              $display("       corner%0d expected %0d actual %0d", c, want.corners[c],
                       seen.corners[c]);
          end
        end
      end
    end
  end

  // Ends the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (!rst && expected_mappings.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("hex_mesh_element_index_mapper_core verification failed");
        $finish;
      end
    end
  end

  // Corners, edges, every face and the Dirichlet marker on the reset grid.
  task automatic test_reset_grid();
    int unsigned bt;
    bt = boundary_total();
    send_request(1'b0, '0);
    send_request(1'b0, NUM_W'(30 * 30 * 30 - 1));
    send_request(1'b0, NUM_W'(30 * 30 * 30));
    send_request(1'b1, '0);
    for (int f = 0; f < 6; f++) send_request(1'b1, NUM_W'(f * 900 + 5));
    send_request(1'b1, NUM_W'(bt - 1));
    send_request(1'b1, NUM_W'(bt));
    send_request(1'b1, '1);
    send_request(1'b0, '1);
    send_request(1'b0, NUM_W'(20'h55555));
    send_request(1'b0, NUM_W'(20'h0AAAA));
  endtask

  // Nonzero codes on all faces, so index zero carries no marker; then the all-zero set, which marks it.
  task automatic test_face_codes();
    set_grid(3, 4, 5, 24'hFEDCBA);
    for (int f = 0; f < 8; f++) send_request(1'b1, NUM_W'(f * 13));
    send_request(1'b1, '0);
    set_grid(3, 4, 5, 24'h000000);
    send_request(1'b1, '0);
    send_request(1'b1, NUM_W'(1));
  endtask

  // Zero and oversized counts, the largest grid and a single cell.
  task automatic test_count_extremes();
    set_grid(0, 127, 64, 24'hFFFFFF);
    repeat (40) send_random_request();
    set_grid(64, 64, 64, 24'h123456);
    send_request(1'b0, NUM_W'(64 * 64 * 64 - 1));
    send_request(1'b1, NUM_W'(6 * 64 * 64 - 1));
    repeat (40) send_random_request();
    set_grid(1, 1, 1, 24'h000000);
    repeat (20) send_random_request();
  endtask

  task automatic test_random_grids();
    for (int phase = 0; phase < 8; phase++) begin
      set_grid($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 70),
               BC_W'($urandom));
      repeat (110) send_random_request();
      // Once, hold the sender until every result has come back.
      if (phase == 3) begin
        release_request();
        while (expected_mappings.size() != 0) @(posedge clk);
      end
    end
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_full_rate();
    set_grid($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
             BC_W'($urandom));
    stall_enable = 1'b0;
    repeat (150) send_random_request();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_grid();
    test_face_codes();
    test_count_extremes();
    test_random_grids();
    test_full_rate();
    release_request();
    while (expected_mappings.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Checked %0d results: %0d boundary requests, %0d out of range.",
             checked_count, boundary_count, range_error_count);
    if (mismatch_count == 0) begin
      $display("hex_mesh_element_index_mapper_core verification clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("hex_mesh_element_index_mapper_core verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/hmap_pkg.sv
design/hmap_if.sv
design/hex_mesh_element_index_mapper_core.sv
test/hex_mesh_element_index_mapper_core_test.sv
